// File: design/refcounted_page_frame_allocator_unit_assert.svh
// assertion macros used by the allocator datapath
`ifndef REFCOUNTED_PAGE_FRAME_ALLOCATOR_UNIT_ASSERT_SVH
`define REFCOUNTED_PAGE_FRAME_ALLOCATOR_UNIT_ASSERT_SVH

// same-cycle implication, clocked on clk_i, off during reset
`define RPFA_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, clocked on clk_i, off during reset
`define RPFA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: design/rpfa_pkg.sv
`default_nettype none

package rpfa_pkg;

  localparam int unsigned PAGE_SIZE = 4096;
  localparam int unsigned NUM_PAGES = 65536;

  localparam int unsigned ADDR_W = 28;
  localparam int unsigned CFG_W  = 29;
  localparam int unsigned REF_W  = 16;
  localparam int unsigned CNT_W  = 17;

  localparam logic [REF_W-1:0] REF_MAX = 16'hffff;

  typedef enum logic [1:0] {
    KIND_ALLOC = 2'd0,
    KIND_FREE  = 2'd1,
    KIND_INCR  = 2'd2,
    KIND_INIT  = 2'd3
  } kind_e;

  typedef enum logic [2:0] {
    STAT_OK     = 3'd0,
    STAT_EMPTY  = 3'd1,
    STAT_RANGE  = 3'd2,
    STAT_UNUSED = 3'd3,
    STAT_SAT    = 3'd4,
    STAT_NULL   = 3'd5
  } status_e;

  typedef enum logic [1:0] {
    S_CLEAR = 2'd0,
    S_IDLE  = 2'd1,
    S_SWEEP = 2'd2,
    S_EXEC  = 2'd3
  } state_e;

  typedef struct packed {
    kind_e             kind;
    logic [ADDR_W-1:0] page_addr;
  } req_t;

  typedef struct packed {
    status_e           status;
    logic [ADDR_W-1:0] result_addr;
    logic [CNT_W-1:0]  free_count;
    logic [REF_W-1:0]  ref_count;
  } rsp_t;

  typedef struct packed {
    logic accept;
    logic clear_en;
    logic sweep_en;
    logic exec_en;
  } ctrl_cmd_t;

  typedef struct packed {
    logic sweep_last;
  } dp_stat_t;

endpackage

`default_nettype wire

// File: design/rpfa_ram.sv
`default_nettype none

module rpfa_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// File: design/rpfa_ctrl.sv
`default_nettype none

module rpfa_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  rpfa_pkg::kind_e     kind_i,
  input  rpfa_pkg::dp_stat_t  stat_i,
  output rpfa_pkg::ctrl_cmd_t cmd_o,
  output logic                busy_o
);

  import rpfa_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    busy_o  = 1'b1;
    unique case (state_q)
      S_CLEAR: begin
        cmd_o.clear_en = 1'b1;
        if (stat_i.sweep_last) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        busy_o = 1'b0;
        if (start_i) begin
          cmd_o.accept = 1'b1;
          state_d      = (kind_i == KIND_INIT) ? S_SWEEP : S_EXEC;
        end
      end
      S_SWEEP: begin
        cmd_o.sweep_en = 1'b1;
        if (stat_i.sweep_last) begin
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd_o.exec_en = 1'b1;
        state_d       = S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// File: design/rpfa_datapath.sv
`default_nettype none
`include "refcounted_page_frame_allocator_unit_assert.svh"

module rpfa_datapath (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  rpfa_pkg::req_t                   req_i,
  input  logic                             cfg_we_i,
  input  logic [rpfa_pkg::CFG_W-1:0]       cfg_data_i,
  input  rpfa_pkg::ctrl_cmd_t              cmd_i,
  output rpfa_pkg::dp_stat_t               stat_o,
  output rpfa_pkg::rsp_t                   rsp_o,
  output logic                             done_o
);

  import rpfa_pkg::*;

  localparam int unsigned PAGE_SHIFT = $clog2(PAGE_SIZE);
  localparam int unsigned IDX_W      = $clog2(NUM_PAGES);
  localparam int unsigned FT_W       = IDX_W + 1;
  localparam int unsigned IDXF_W     = ADDR_W + IDX_W;
  localparam int unsigned ST_W       = REF_W + 1;
  localparam logic [63:0] REGION_END = 64'(NUM_PAGES) << PAGE_SHIFT;
  localparam logic [CFG_W:0] ROUND_ADD = (CFG_W + 1)'(PAGE_SIZE - 1);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_PAGES - 1);

  logic [CFG_W-1:0]  cfg_q;
  req_t              item_q;
  logic [IDX_W-1:0]  head_q, head_d;
  logic [FT_W-1:0]   ft_q, ft_d;
  logic [IDX_W-1:0]  sweep_q, sweep_d;
  rsp_t              rsp_q, rsp_d;
  logic              done_q;

  logic [CFG_W:0]    start_ceil;
  logic              sweep_push;
  logic [IDXF_W-1:0] req_wide, item_wide, alloc_wide;
  logic [IDX_W-1:0]  req_idx, item_idx;
  logic              is_null, aligned, in_range, located;

  logic              st_we, link_we;
  logic [IDX_W-1:0]  st_waddr, link_waddr;
  logic [ST_W-1:0]   st_wdata, st_rd;
  logic [IDX_W-1:0]  link_wdata, link_rd;
  logic              rd_use;
  logic [REF_W-1:0]  rd_refs;

  status_e           ex_status;
  logic [ADDR_W-1:0] ex_addr;
  logic [REF_W-1:0]  ex_ref;
  logic              ex_st_we, ex_push, ex_pop;
  logic [ST_W-1:0]   ex_wdata;
  logic [IDX_W-1:0]  ex_idx;

  // lowest page init puts on the free list, never page zero
  assign start_ceil = ({1'b0, cfg_q} + ROUND_ADD) >> PAGE_SHIFT;
  assign sweep_push = (64'(sweep_q) >= 64'(start_ceil)) && (sweep_q != '0);

  assign req_wide   = IDXF_W'(req_i.page_addr) >> PAGE_SHIFT;
  assign item_wide  = IDXF_W'(item_q.page_addr) >> PAGE_SHIFT;
  assign alloc_wide = IDXF_W'(head_q) << PAGE_SHIFT;
  assign req_idx    = req_wide[IDX_W-1:0];
  assign item_idx   = item_wide[IDX_W-1:0];

  assign is_null  = (item_q.page_addr == '0);
  assign aligned  = (item_q.page_addr[PAGE_SHIFT-1:0] == '0);
  assign in_range = ({1'b0, item_q.page_addr} >= cfg_q) &&
                    (64'(item_q.page_addr) < REGION_END);
  assign located  = aligned && in_range;

  assign rd_use  = st_rd[REF_W];
  assign rd_refs = st_rd[REF_W-1:0];

  // page state: in-use flag over refcount
  rpfa_ram #(
    .WIDTH(ST_W),
    .DEPTH(NUM_PAGES)
  ) u_state_ram (
    .clk_i  (clk_i),
    .we_i   (st_we),
    .waddr_i(st_waddr),
    .wdata_i(st_wdata),
    .raddr_i(req_idx),
    .rdata_o(st_rd)
  );

  rpfa_ram #(
    .WIDTH(IDX_W),
    .DEPTH(NUM_PAGES)
  ) u_link_ram (
    .clk_i  (clk_i),
    .we_i   (link_we),
    .waddr_i(link_waddr),
    .wdata_i(link_wdata),
    .raddr_i(head_q),
    .rdata_o(link_rd)
  );

  always_comb begin
    ex_status = STAT_OK;
    ex_addr   = '0;
    ex_ref    = '0;
    ex_st_we  = 1'b0;
    ex_wdata  = '0;
    ex_idx    = item_idx;
    ex_push   = 1'b0;
    ex_pop    = 1'b0;
    if (item_q.kind == KIND_INIT) begin
      ex_status = STAT_OK;
    end else if (item_q.kind == KIND_ALLOC) begin
      if (ft_q == '0) begin
        ex_status = STAT_EMPTY;
      end else begin
        ex_pop   = 1'b1;
        ex_idx   = head_q;
        ex_st_we = 1'b1;
        ex_wdata = {1'b1, REF_W'(1)};
        ex_addr  = alloc_wide[ADDR_W-1:0];
        ex_ref   = REF_W'(1);
      end
    end else if (is_null) begin
      ex_status = STAT_NULL;
    end else if (!located) begin
      ex_status = STAT_RANGE;
    end else if (item_q.kind == KIND_INCR) begin
      ex_ref = rd_refs;
      if (!rd_use || (rd_refs == '0)) begin
        ex_status = STAT_UNUSED;
      end else if (rd_refs == REF_MAX) begin
        ex_status = STAT_SAT;
      end else begin
        ex_st_we = 1'b1;
        ex_wdata = {1'b1, rd_refs + REF_W'(1)};
        ex_ref   = rd_refs + REF_W'(1);
      end
    end else begin
      if (!rd_use) begin
        ex_status = STAT_UNUSED;
        ex_ref    = rd_refs;
      end else if (rd_refs > REF_W'(1)) begin
        ex_st_we = 1'b1;
        ex_wdata = {1'b1, rd_refs - REF_W'(1)};
        ex_ref   = rd_refs - REF_W'(1);
      end else begin
        ex_st_we = 1'b1;
        ex_wdata = '0;
        ex_push  = 1'b1;
      end
    end
  end

  always_comb begin
    head_d     = head_q;
    ft_d       = ft_q;
    sweep_d    = sweep_q;
    st_we      = 1'b0;
    st_waddr   = sweep_q;
    st_wdata   = {1'b1, REF_W'(0)};
    link_we    = 1'b0;
    link_waddr = sweep_q;
    link_wdata = head_q;
    if (cmd_i.accept && (req_i.kind == KIND_INIT)) begin
      head_d  = '0;
      ft_d    = '0;
      sweep_d = '0;
    end
    if (cmd_i.clear_en) begin
      st_we   = 1'b1;
      sweep_d = sweep_q + IDX_W'(1);
    end
    if (cmd_i.sweep_en) begin
      st_we    = 1'b1;
      st_wdata = {!sweep_push, REF_W'(0)};
      sweep_d  = sweep_q + IDX_W'(1);
      if (sweep_push) begin
        link_we = 1'b1;
        head_d  = sweep_q;
        ft_d    = ft_q + FT_W'(1);
      end
    end
    if (cmd_i.exec_en) begin
      st_we    = ex_st_we;
      st_waddr = ex_idx;
      st_wdata = ex_wdata;
      if (ex_pop) begin
        head_d = link_rd;
        ft_d   = ft_q - FT_W'(1);
      end
      if (ex_push) begin
        link_we    = 1'b1;
        link_waddr = ex_idx;
        head_d     = ex_idx;
        ft_d       = ft_q + FT_W'(1);
      end
    end
    rsp_d.status      = ex_status;
    rsp_d.result_addr = ex_addr;
    rsp_d.free_count  = CNT_W'(ft_d);
    rsp_d.ref_count   = ex_ref;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q   <= '0;
      head_q  <= '0;
      ft_q    <= '0;
      sweep_q <= '0;
      done_q  <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        cfg_q <= cfg_data_i;
      end
      head_q  <= head_d;
      ft_q    <= ft_d;
      sweep_q <= sweep_d;
      done_q  <= cmd_i.exec_en;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      item_q <= req_i;
    end
    if (cmd_i.exec_en) begin
      rsp_q <= rsp_d;
    end
  end

  assign stat_o.sweep_last = (sweep_q == LAST_IDX);
  assign rsp_o  = rsp_q;
  assign done_o = done_q;

  `RPFA_ASSERT_NEXT(a_done_after_exec, cmd_i.exec_en, done_q, "no result after execute")
  `RPFA_ASSERT_IMP(a_done_only_after_exec, done_q, $past(cmd_i.exec_en), "stray result strobe")
  `RPFA_ASSERT_IMP(a_free_bounded, 1'b1, ft_q <= FT_W'(NUM_PAGES), "free count above page count")
  `RPFA_ASSERT_NEXT(a_alloc_pops, cmd_i.exec_en && item_q.kind == KIND_ALLOC && ft_q != '0, ft_q == $past(ft_q) - FT_W'(1), "alloc did not pop one page")

endmodule

`default_nettype wire

// File: design/refcounted_page_frame_allocator_unit.sv
`default_nettype none
// page frame allocator with per-page reference counts and a LIFO free list
// request channel: req_i is taken at a rising edge with start high and busy low;
//   kind selects alloc, free, increment reference or initialize
// result channel: rsp_o is flagged by done_o, high for one cycle; no back-pressure,
//   the receiver must take it in that cycle
// config channel: cfg_data_i (kernel end address) is written when cfg_valid_i and
//   cfg_ready_o are high; ready is always high, write only while the unit is idle
// alloc, free and increment: the page state and link memories are read at the
//   accepting edge and updated in the EXEC state; done_o rises at the edge after
//   the accepting one and a new request can be taken while done_o is high
// initialize: a sweep steps through every page of both memories, followed by the
//   EXEC state; done_o rises when EXEC ends and busy stays high throughout
// reset: the page state memory is cleared to in use with zero references by a pass
//   over every page; busy is high during that pass, config writes still go in
module refcounted_page_frame_allocator_unit (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start,
  output logic                       busy,
  input  rpfa_pkg::req_t             req_i,
  output rpfa_pkg::rsp_t             rsp_o,
  output logic                       done_o,
  input  logic                       cfg_valid_i,
  output logic                       cfg_ready_o,
  input  logic [rpfa_pkg::CFG_W-1:0] cfg_data_i
);

  import rpfa_pkg::*;

  ctrl_cmd_t cmd;
  dp_stat_t  stat;

  assign cfg_ready_o = 1'b1;

  rpfa_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start),
    .kind_i (req_i.kind),
    .stat_i (stat),
    .cmd_o  (cmd),
    .busy_o (busy)
  );

  rpfa_datapath u_datapath (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req_i     (req_i),
    .cfg_we_i  (cfg_valid_i && cfg_ready_o),
    .cfg_data_i(cfg_data_i),
    .cmd_i     (cmd),
    .stat_o    (stat),
    .rsp_o     (rsp_o),
    .done_o    (done_o)
  );

endmodule

`default_nettype wire
